[src/spq_pkg.sv]
// ============================================================================
// spq_pkg: shared types and constants for the sorted priority queue
// Holds the command and status codes, the transfer payload structs and the
// per-cell control and entry structs used by the cell row.
// ============================================================================
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CNT_W           = 5;
  localparam int VAL_W           = 32;
  localparam int PRIO_W          = 16;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [VAL_W-1:0]   item_value;
    logic signed [PRIO_W-1:0]  item_priority;
  } in_data_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VAL_W-1:0]   head_value;
    logic [CNT_W-1:0]          entry_count;
    logic                      is_empty;
    logic                      is_full;
  } out_data_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]   value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // Broadcast to every cell: what happens this cycle and the new entry.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[src/spq_cell.sv]
// ============================================================================
// spq_cell: one slot of the sorted cell row
// Holds one entry, compares its priority against the broadcast item and
// either keeps its entry, takes the new item, or takes a neighbor's entry.
// ============================================================================
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               left_ge,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire spq_pkg::entry_t    right_entry,
  output logic                    ge,
  output spq_pkg::entry_t         entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Entries of equal priority stay ahead of the new item, so ties leave in
  // arrival order.
  assign ge    = occupied && (entry_r.prio >= ctrl.item.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.enq) begin
      if (ge) begin
        entry_nxt = entry_r;
      end else if (left_ge) begin
        entry_nxt = ctrl.item;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
    end else begin
      // No enqueue or dequeue this cycle: the cell holds its entry.
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

[src/sorted_priority_queue.sv]
// ============================================================================
// sorted_priority_queue: bounded priority queue in a sorted cell row
// Keeps value and priority pairs sorted by descending priority; serves
// enqueue, dequeue and peek commands with one result per command.
// ============================================================================
// A result is presented in the cycle after its command transfer.
// Throughput: one command per cycle, set by the compare-and-shift
// of the row; a new command is taken while a result waits, as long as that
// result is taken in the same cycle.
// Reset (rst_n low, synchronous): the queue becomes empty, the capacity limit
// returns to 16 and no result is pending. Entry storage is not cleared.
`default_nettype none

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire spq_pkg::in_data_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output spq_pkg::out_data_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [spq_pkg::CNT_W-1:0]     cfg_data
);

  localparam int CNT_W = spq_pkg::CNT_W;

  // Occupancy, capacity register and the registered result.
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    cap_r;
  logic                out_valid_r;
  spq_pkg::out_data_t  out_data_r, out_data_nxt;

  logic                in_fire;
  logic [CNT_W-1:0]    cap_eff;
  logic                is_full_now;
  logic                is_empty_now;
  spq_pkg::cell_ctrl_t ctrl;

  // Cell row wiring. Index i of ge_w and ent_w belongs to cell i.
  logic                ge_w  [QUEUE_DEPTH];
  spq_pkg::entry_t     ent_w [QUEUE_DEPTH];

  // The output register frees as soon as its result is taken, so a new
  // command can transfer in that same cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The effective capacity is the smaller of the register and the depth.
  // When the depth is at least 32 the register always wins, so the
  // truncated depth in the other branch is never selected.
  assign cap_eff = (int'(cap_r) < QUEUE_DEPTH) ? cap_r : CNT_W'(QUEUE_DEPTH);

  assign is_full_now  = (count_r >= cap_eff);
  assign is_empty_now = (count_r == '0);

  // Only successful enqueues and dequeues move the row.
  always_comb begin
    ctrl.enq        = in_fire && (in_data.command == spq_pkg::CMD_ENQ) && !is_full_now;
    ctrl.deq        = in_fire && (in_data.command == spq_pkg::CMD_DEQ) && !is_empty_now;
    ctrl.item.value = in_data.item_value;
    ctrl.item.prio  = in_data.item_priority;
  end

  // The row of cells. Cell 0 always sees a "greater or equal" neighbor on
  // its left, so it takes the new item whenever it loses the compare itself.
  // The outer ends take the new item as filler; those values are never used.
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic            left_ge_w;
    spq_pkg::entry_t left_ent_w;
    spq_pkg::entry_t right_ent_w;

    if (gi == 0) begin : g_first
      assign left_ge_w  = 1'b1;
      assign left_ent_w = ctrl.item;
    end else begin : g_mid
      assign left_ge_w  = ge_w[gi-1];
      assign left_ent_w = ent_w[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent_w = ctrl.item;
    end else begin : g_inner
      assign right_ent_w = ent_w[gi+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (int'(count_r) > gi),
      .left_ge     (left_ge_w),
      .left_entry  (left_ent_w),
      .right_entry (right_ent_w),
      .ge          (ge_w[gi]),
      .entry       (ent_w[gi])
    );
  end

  // Result of the command that transfers this cycle. The head value comes
  // from cell 0 before the row moves, which is what dequeue and peek return.
  always_comb begin
    count_nxt               = count_r;
    out_data_nxt.status     = spq_pkg::ST_DONE;
    out_data_nxt.head_value = '0;
    unique case (in_data.command)
      spq_pkg::CMD_ENQ: begin
        if (is_full_now) begin
          out_data_nxt.status = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      spq_pkg::CMD_DEQ: begin
        if (is_empty_now) begin
          out_data_nxt.status = spq_pkg::ST_EMPTY;
        end else begin
          out_data_nxt.head_value = ent_w[0].value;
          count_nxt               = count_r - CNT_W'(1);
        end
      end
      spq_pkg::CMD_PEEK: begin
        if (is_empty_now) begin
          out_data_nxt.status = spq_pkg::ST_EMPTY;
        end else begin
          out_data_nxt.head_value = ent_w[0].value;
        end
      end
      default: begin
        // The unused code does nothing and reports done.
        count_nxt = count_r;
      end
    endcase
    out_data_nxt.entry_count = count_nxt;
    out_data_nxt.is_empty    = (count_nxt == '0);
    out_data_nxt.is_full     = (count_nxt >= cap_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= spq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // The occupancy never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= QUEUE_DEPTH)
    else $error("occupancy exceeds queue depth");

  // A successful enqueue grows the queue by exactly one.
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.enq |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not advance occupancy");

  // A pending result that was not taken blocks new commands.
  a_hold_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("command taken while result stalled");

  // A result that is not done carries a zero head value.
  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != spq_pkg::ST_DONE)) |->
      (out_data_r.head_value == '0))
    else $error("non-zero head value on failed command");

  // The reported count matches the occupancy after the command.
  a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r && (out_data_r.entry_count == count_r)))
    else $error("reported entry count differs from occupancy");

endmodule

`default_nettype wire

[sim/spq_order_checker.sv]
// ============================================================================
// spq_order_checker: result checker for the sorted priority queue
// Watches the command, result and capacity channels, keeps its own sorted
// copy of the queue and compares every result transfer with the oldest
// predicted one.
// ============================================================================
module spq_order_checker #(
  parameter int DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire spq_pkg::in_data_t         in_data,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire spq_pkg::out_data_t        out_data,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [spq_pkg::CNT_W-1:0] cfg_data,
  output int unsigned                    mismatch_count,
  output int unsigned                    awaited_count,
  output int unsigned                    results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [spq_pkg::VAL_W-1:0]  val_q  [DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] prio_q [DEPTH];
  logic [spq_pkg::CNT_W-1:0]         held;
  logic [spq_pkg::CNT_W-1:0]         cap_limit;
  spq_pkg::out_data_t                awaited_results [$];

  // Applies one command to the local copy of the queue and returns the
  // result the block must give for it.
  function automatic spq_pkg::out_data_t serve_command(input spq_pkg::in_data_t cmd_in);
    spq_pkg::out_data_t        res;
    logic [spq_pkg::CNT_W-1:0] room;
    int                        slot;
    room = (cap_limit < DEPTH) ? cap_limit : spq_pkg::CNT_W'(DEPTH);
    res = '0;
    res.status = spq_pkg::ST_DONE;
    case (cmd_in.command)
      spq_pkg::CMD_ENQ: begin
        if (held >= room || held >= DEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          // Equal priorities go behind the ones already stored.
          slot = 0;
          while (slot < held && $signed(prio_q[slot]) >= $signed(cmd_in.item_priority))
            slot++;
          for (int i = held; i > slot; i--) begin
            val_q[i]  = val_q[i-1];
            prio_q[i] = prio_q[i-1];
          end
          val_q[slot]  = cmd_in.item_value;
          prio_q[slot] = cmd_in.item_priority;
          held++;
        end
      end
      spq_pkg::CMD_DEQ: begin
        if (held == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          res.head_value = val_q[0];
          for (int i = 1; i < held; i++) begin
            val_q[i-1]  = val_q[i];
            prio_q[i-1] = prio_q[i];
          end
          held--;
        end
      end
      spq_pkg::CMD_PEEK: begin
        if (held == 0) res.status = spq_pkg::ST_EMPTY;
        else res.head_value = val_q[0];
      end
      default: ;
    endcase
    res.entry_count = held;
    res.is_empty    = (held == 0);
    res.is_full     = (held >= room);
    return res;
  endfunction

  task automatic flag_field(input string name, input logic [63:0] want_v,
                            input logic [63:0] got_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    spq_pkg::out_data_t want;
    if (!rst_n) begin
      held           = '0;
      cap_limit      = spq_pkg::CAP_RESET;
      mismatch_count = 0;
      results_seen   = 0;
      awaited_results.delete();
    end else begin
      // A command in the same cycle as a capacity write still sees the old
      // capacity, as the block does.
      if (in_valid && in_ready) awaited_results.push_back(serve_command(in_data));
      if (cfg_valid && cfg_ready) cap_limit = cfg_data;
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %0h",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status)
            flag_field("status", want.status, out_data.status);
          if (out_data.head_value !== want.head_value)
            flag_field("head_value", want.head_value, out_data.head_value);
          if (out_data.entry_count !== want.entry_count)
            flag_field("entry_count", want.entry_count, out_data.entry_count);
          if (out_data.is_empty !== want.is_empty)
            flag_field("is_empty", want.is_empty, out_data.is_empty);
          if (out_data.is_full !== want.is_full)
            flag_field("is_full", want.is_full, out_data.is_full);
        end
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

[sim/tb_sorted_priority_queue.sv]
// ============================================================================
// tb_sorted_priority_queue: regression bench for the sorted priority queue
// Drives enqueue, dequeue, peek and the unused command code through the
// command channel with random idling on both sides, rewrites the capacity
// between phases, and leaves all checking to the order checker beside it.
// ============================================================================
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  // The command field has a fourth code that the block must treat as a no-op.
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 85;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  spq_pkg::in_data_t         in_data   = '0;
  logic                      out_ready = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [spq_pkg::CNT_W-1:0] cfg_data  = '0;
  logic                      in_ready;
  logic                      out_valid;
  logic                      cfg_ready;
  spq_pkg::out_data_t        out_data;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned results_seen;

  // When set, neither side idles; the last phase runs at full rate.
  bit          calm        = 1'b0;
  int unsigned ready_hold  = 0;
  int unsigned cycle_count = 0;
  int unsigned cap_writes  = 0;
  int unsigned sent [4]    = '{default: 0};

  // Capacity for each random phase: the full depth, a value past the depth,
  // the smallest sizes and zero all come up at least once.
  logic [spq_pkg::CNT_W-1:0] phase_cap [PHASES] = '{5'd16, 5'd31, 5'd1, 5'd0,
                                                   5'd16, 5'd5, 5'd31, 5'd2,
                                                   5'd16, 5'd9, 5'd31, 5'd16};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_priority_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  spq_order_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .awaited_count  (awaited),
    .results_seen   (results_seen)
  );

  // The result side stalls in random bursts. A stall starts
  // with the cycle that picks it and holds while ready_hold counts down.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, awaited);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one command and returns at the edge of its transfer. A random
  // idle gap may come first. Valid stays high between back-to-back
  // commands, so it gets a single assignment at each edge.
  task automatic issue(input logic [1:0] code, input logic [spq_pkg::VAL_W-1:0] val,
                       input logic [spq_pkg::PRIO_W-1:0] pri);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= spq_pkg::in_data_t'({code, val, pri});
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent[code]++;
  endtask

  // Holds the sender back until every predicted result has been taken. The
  // count is read at the falling edge, away from the edge where it changes.
  // A result comes in the cycle after its command, so once none is
  // awaited the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The capacity is only rewritten while the queue has nothing in flight.
  task automatic write_capacity(input logic [spq_pkg::CNT_W-1:0] cap);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // One random phase. Enqueues take enq_pct percent of the commands, peeks
  // and the unused code a few more, and the rest are dequeues; a high share
  // fills the queue to its limit, a low one drains it.
  task automatic run_phase(input logic [spq_pkg::CNT_W-1:0] cap,
                           input int unsigned enq_pct);
    logic [1:0]                 code;
    logic [spq_pkg::PRIO_W-1:0] pri;
    int unsigned                pick;
    write_capacity(cap);
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) code = spq_pkg::CMD_ENQ;
      else if (pick < enq_pct + 6) code = spq_pkg::CMD_PEEK;
      else if (pick < enq_pct + 8) code = CMD_UNUSED;
      else code = spq_pkg::CMD_DEQ;
      // Close priorities make many ties, so arrival order among equals is
      // checked often; the others span the whole signed range.
      case ($urandom_range(0, 3))
        0: pri = spq_pkg::PRIO_W'($urandom_range(0, 3)) - spq_pkg::PRIO_W'(1);
        1: pri = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
        default: pri = spq_pkg::PRIO_W'($urandom);
      endcase
      issue(code, spq_pkg::VAL_W'($urandom), pri);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue at the reset capacity: peek, dequeue and the unused code.
    issue(spq_pkg::CMD_PEEK, 32'h0, 16'h0);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);
    issue(CMD_UNUSED, 32'h0, 16'h0);
    // Field extremes, then three equal priorities that must leave in the
    // order they came.
    issue(spq_pkg::CMD_ENQ, 32'h7FFFFFFF, 16'h7FFF);
    issue(spq_pkg::CMD_ENQ, 32'h80000000, 16'h8000);
    issue(spq_pkg::CMD_ENQ, 32'h00000000, 16'h0000);
    issue(spq_pkg::CMD_ENQ, 32'hFFFFFFFF, 16'h0000);
    issue(spq_pkg::CMD_ENQ, 32'h000004D2, 16'h0000);
    issue(spq_pkg::CMD_PEEK, 32'h0, 16'h0);
    // The unused code with busy fields must leave the queue alone.
    issue(CMD_UNUSED, 32'hFFFFFFFF, 16'hFFFF);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);

    // Capacity lowered below the three stored entries: they are kept, and
    // enqueues are refused until the count drops under the new limit.
    write_capacity(spq_pkg::CNT_W'(2));
    issue(spq_pkg::CMD_ENQ, 32'h12345678, 16'h1234);
    issue(spq_pkg::CMD_PEEK, 32'h0, 16'h0);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);
    issue(spq_pkg::CMD_ENQ, 32'h12345678, 16'h1234);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);
    issue(spq_pkg::CMD_ENQ, 32'h55555555, 16'h5555);

    // Capacity zero: nothing can be added, and an empty queue is also full.
    write_capacity(spq_pkg::CNT_W'(0));
    issue(spq_pkg::CMD_ENQ, 32'h0BADF00D, 16'h0001);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);
    issue(spq_pkg::CMD_ENQ, 32'h0BADF00D, 16'h0001);

    // A capacity past the depth is bounded by the depth.
    write_capacity(spq_pkg::CNT_W'(31));
    issue(spq_pkg::CMD_ENQ, 32'hAAAAAAAA, 16'hAAAA);
    issue(spq_pkg::CMD_DEQ, 32'h0, 16'h0);

    // Random phases alternate between filling and draining the queue. Two
    // of them take a capacity chosen at random, and the last one runs with
    // no idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) calm = 1'b1;
      run_phase((ph == 4 || ph == 8) ? spq_pkg::CNT_W'($urandom_range(0, 31))
                                     : phase_cap[ph],
                (ph % 2 == 0) ? 65 : 30);
    end

    settle();
    @(negedge clk);
    $display("Covered %0d commands (%0d enqueue, %0d dequeue, %0d peek, %0d unused),",
             sent[0] + sent[1] + sent[2] + sent[3], sent[spq_pkg::CMD_ENQ],
             sent[spq_pkg::CMD_DEQ], sent[spq_pkg::CMD_PEEK], sent[CMD_UNUSED]);
    $display("%0d results; capacity rewritten %0d times, through zero, one, %s",
             results_seen, cap_writes, "the full depth and past it.");
    if (mismatches == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
